### hw/rtl/spr_pkg.sv
// Shared types and codes for the service port registry table.
// No dependencies; imported by the entry memory, the top level, the checker and the testbench top.

package spr_pkg;

  // request codes
  localparam logic [1:0] REQ_REGISTER = 2'd0;
  localparam logic [1:0] REQ_RESOLVE  = 2'd1;
  localparam logic [1:0] REQ_FORGET   = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // largest count the result field can show
  localparam logic [6:0] COUNT_MAX = 7'd127;

  // one request transfer
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] service_key;
    logic [15:0] port_value;
  } spr_req_t;

  // one result transfer
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] port_found;
    logic [6:0]  entry_count;
  } spr_rsp_t;

  // one table slot as held in the entry memory
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [15:0] port;
  } spr_entry_t;

endpackage

### hw/rtl/spr_entry_mem.sv
// Entry memory of the service port registry: one write port, one read port,
// registered read data. Depends on spr_pkg for the slot type.

module spr_entry_mem
  import spr_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  spr_entry_t        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output spr_entry_t        rd_data
);

  spr_entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/service_port_registry_table_unit.sv
// Top level of the service port registry: request sequencer that scans the
// entry memory, then writes back and reports. Depends on spr_pkg, spr_entry_mem.
//
//   channel  ports                       transfer
//   request  start, busy, in_item        start high and busy low at a clock edge
//   result   out_strobe, out_item        out_strobe high for one cycle
//
// A request runs from its transfer to its result strobe through one memory
// read per slot, the registered read data, then decision and write-back;
// the single read port of the entry memory keeps the scan to one slot at a time.
// After reset a clearing pass, one slot at a time, marks every slot free;
// busy stays high through it. Reset is synchronous, active low.
// Results cannot be held off; a new request may be taken in the strobe cycle.

module service_port_registry_table_unit
  import spr_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  spr_req_t in_item,
  output logic     out_strobe,
  output spr_rsp_t out_item
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CTR_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CMP_W = (CTR_W > 7) ? CTR_W : 7;

  localparam logic [CTR_W-1:0] CTR_END  = CTR_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_WB    = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CTR_W-1:0] cnt_r;
  logic [CTR_W-1:0] count_r, count_nxt;
  spr_req_t         req_r;
  logic             chk_vld_r;
  logic [IDX_W-1:0] chk_idx_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [15:0]      hit_port_r;
  logic             free_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             out_strobe_r;
  spr_rsp_t         out_item_r;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  spr_entry_t       rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  spr_entry_t       wr_data;

  logic             accept;
  logic             key_hit;
  logic             free_seen;
  logic             last_chk;
  spr_rsp_t         rsp;
  logic [CMP_W-1:0] count_ext;

  spr_entry_mem #(
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // scan reads, one slot a cycle
  assign rd_en   = (state_r == S_SCAN) && (cnt_r != CTR_END);
  assign rd_addr = cnt_r[IDX_W-1:0];

  // compare the slot whose data came back this cycle
  assign key_hit   = chk_vld_r && rd_data.valid && (rd_data.key == req_r.service_key);
  assign free_seen = chk_vld_r && !rd_data.valid;
  assign last_chk  = chk_vld_r && (chk_idx_r == IDX_LAST);

  // decision, write-back and result
  always_comb begin
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_addr   = cnt_r[IDX_W-1:0];
    wr_data   = '0;
    rsp.status      = ST_DONE;
    rsp.port_found  = '0;
    rsp.entry_count = '0;
    if (state_r == S_CLEAR) begin
      wr_en = 1'b1;
    end else if (state_r == S_WB) begin
      case (req_r.req_type)
        REQ_REGISTER: begin
          if (hit_r) begin
            wr_en   = 1'b1;
            wr_addr = hit_idx_r;
            wr_data = '{valid: 1'b1, key: req_r.service_key, port: req_r.port_value};
          end else if (free_r) begin
            wr_en     = 1'b1;
            wr_addr   = free_idx_r;
            wr_data   = '{valid: 1'b1, key: req_r.service_key, port: req_r.port_value};
            count_nxt = count_r + 1'b1;
          end else begin
            rsp.status = ST_FULL;
          end
        end
        REQ_RESOLVE: begin
          if (hit_r) begin
            rsp.port_found = hit_port_r;
          end else begin
            rsp.status = ST_MISSING;
          end
        end
        REQ_FORGET: begin
          if (hit_r) begin
            wr_en   = 1'b1;
            wr_addr = hit_idx_r;
            wr_data = '{valid: 1'b0, key: req_r.service_key, port: hit_port_r};
            if (count_r != '0) begin
              count_nxt = count_r - 1'b1;
            end
          end else begin
            rsp.status = ST_MISSING;
          end
        end
        default: begin
          // unused request code leaves the table alone
        end
      endcase
    end
    count_ext       = CMP_W'(count_nxt);
    rsp.entry_count = (count_ext > CMP_W'(COUNT_MAX)) ? COUNT_MAX : count_ext[6:0];
  end

  // sequencing
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (cnt_r[IDX_W-1:0] == IDX_LAST) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_SCAN;
      S_SCAN:  if (last_chk) state_nxt = S_WB;
      S_WB:    state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cnt_r        <= '0;
      count_r      <= '0;
      chk_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= (state_r == S_WB);
      chk_vld_r    <= rd_en;
      if (state_r == S_CLEAR) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (accept) begin
        cnt_r  <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        if (rd_en) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (key_hit && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (free_seen && !free_r) begin
          free_r <= 1'b1;
        end
      end
    end
  end

  // request and scan payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_item;
    end
    chk_idx_r <= rd_addr;
    if (key_hit && !hit_r) begin
      hit_idx_r  <= chk_idx_r;
      hit_port_r <= rd_data.port;
    end
    if (free_seen && !free_r) begin
      free_idx_r <= chk_idx_r;
    end
    if (state_r == S_WB) begin
      out_item_r <= rsp;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

### tb/spr_checker.sv
// Checker for the service port registry table: watches request and result
// transfers, predicts each result from its own copy of the table and compares.
// Depends on spr_pkg for the transfer types and the request and status codes.

module spr_checker
  import spr_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  spr_req_t in_item,
  input  logic     out_strobe,
  input  spr_rsp_t out_item,
  output int       fail_count,
  output int       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the table
  bit          slot_valid [TABLE_ENTRIES];
  logic [31:0] slot_key   [TABLE_ENTRIES];
  logic [15:0] slot_port  [TABLE_ENTRIES];
  int          live_count;

  // replies owed by the block, oldest first
  spr_rsp_t    owed_replies [$];
  int          errors;

  // apply one request to the shadow table and return the reply it earns
  function automatic spr_rsp_t apply_request(spr_req_t r);
    spr_rsp_t rsp;
    int       hit;
    int       free_slot;
    rsp        = '0;
    rsp.status = ST_DONE;
    hit        = -1;
    free_slot  = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit < 0 && slot_valid[i] && slot_key[i] == r.service_key) hit = i;
      if (free_slot < 0 && !slot_valid[i]) free_slot = i;
    end
    case (r.req_type)
      REQ_REGISTER: begin
        if (hit >= 0) begin
          slot_port[hit] = r.port_value;
        end else if (free_slot >= 0) begin
          slot_key[free_slot]   = r.service_key;
          slot_port[free_slot]  = r.port_value;
          slot_valid[free_slot] = 1'b1;
          live_count++;
        end else begin
          rsp.status = ST_FULL;
        end
      end
      REQ_RESOLVE: begin
        if (hit >= 0) rsp.port_found = slot_port[hit];
        else rsp.status = ST_MISSING;
      end
      REQ_FORGET: begin
        if (hit >= 0) begin
          slot_valid[hit] = 1'b0;
          if (live_count > 0) live_count--;
        end else begin
          rsp.status = ST_MISSING;
        end
      end
      default: ;  // unused code leaves the table alone
    endcase
    rsp.entry_count = (live_count > COUNT_MAX) ? COUNT_MAX : live_count[6:0];
    return rsp;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // compare result transfers, then record the request transfer of this edge
  always @(posedge clk) begin : watch
    spr_rsp_t want;
    if (!rst_n) begin
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      live_count = 0;
      owed_replies.delete();
    end else begin
      if (out_strobe) begin
        if (owed_replies.size() == 0) begin
          errors++;
          $error("result transfer with no request outstanding");
        end else begin
          want = owed_replies.pop_front();
          check_field("status", want.status, out_item.status);
          check_field("port_found", want.port_found, out_item.port_found);
          check_field("entry_count", want.entry_count, out_item.entry_count);
        end
      end
      if (start && !busy) owed_replies.push_back(apply_request(in_item));
    end
    fail_count  <= errors;
    outstanding <= owed_replies.size();
  end

endmodule

### tb/tb_top.sv
// Top of the service port registry testbench: clock, reset and request stimulus.
// Depends on spr_pkg, service_port_registry_table_unit and spr_checker.

module tb_top
  import spr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         TABLE_ENTRIES = 64;
  localparam int         KEY_POOL      = 96;
  localparam int         PHASE_ITEMS   = 360;
  localparam logic [1:0] REQ_UNUSED    = 2'd3;

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  spr_req_t in_item = '0;
  logic     busy;
  logic     out_strobe;
  spr_rsp_t out_item;
  int       fail_count;
  int       outstanding;

  // keys reused often enough to hit, and more of them than the table holds
  logic [31:0] key_pool [KEY_POOL];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  service_port_registry_table_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  spr_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) registry_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // one request transfer, after an optional idle gap
  task automatic send_request(spr_req_t r, int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(90, 1)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= r;
    do @(posedge clk); while (busy);
  endtask

  function automatic spr_req_t make_request(logic [1:0] op, logic [31:0] key,
                                            logic [15:0] port);
    spr_req_t r;
    r.req_type    = op;
    r.service_key = key;
    r.port_value  = port;
    return r;
  endfunction

  // random request; filling stretches lean on register, draining on forget
  function automatic spr_req_t random_request(bit filling);
    int          pick;
    logic [1:0]  op;
    logic [31:0] key;
    pick = $urandom_range(99);
    if (filling) begin
      if (pick < 60) op = REQ_REGISTER;
      else if (pick < 82) op = REQ_RESOLVE;
      else if (pick < 97) op = REQ_FORGET;
      else op = REQ_UNUSED;
    end else begin
      if (pick < 20) op = REQ_REGISTER;
      else if (pick < 45) op = REQ_RESOLVE;
      else if (pick < 97) op = REQ_FORGET;
      else op = REQ_UNUSED;
    end
    if ($urandom_range(99) < 10) key = $urandom;
    else key = key_pool[$urandom_range(KEY_POOL - 1)];
    return make_request(op, key, 16'($urandom));
  endfunction

  // hard stop
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int idle_by_phase [4];
    idle_by_phase = '{0, 73, 0, 14};
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every request, misses and the unused code
    send_request(make_request(REQ_RESOLVE,  32'h0000_0000, 16'h0000), 0);
    send_request(make_request(REQ_FORGET,   32'hFFFF_FFFF, 16'hFFFF), 0);
    send_request(make_request(REQ_REGISTER, 32'h0000_0000, 16'h0000), 0);
    send_request(make_request(REQ_REGISTER, 32'hFFFF_FFFF, 16'hFFFF), 0);
    send_request(make_request(REQ_RESOLVE,  32'h0000_0000, 16'hFFFF), 0);
    send_request(make_request(REQ_RESOLVE,  32'hFFFF_FFFF, 16'h0000), 0);
    send_request(make_request(REQ_RESOLVE,  32'h0000_0001, 16'h1234), 0);
    send_request(make_request(REQ_REGISTER, 32'h0000_0000, 16'h8001), 0);
    send_request(make_request(REQ_RESOLVE,  32'h0000_0000, 16'h0000), 0);
    send_request(make_request(REQ_UNUSED,   32'h0000_0000, 16'hFFFF), 0);
    send_request(make_request(REQ_UNUSED,   32'hA5A5_5A5A, 16'h0000), 0);
    send_request(make_request(REQ_FORGET,   32'h0000_0000, 16'h0000), 0);
    send_request(make_request(REQ_RESOLVE,  32'h0000_0000, 16'h0000), 0);
    send_request(make_request(REQ_FORGET,   32'h0000_0000, 16'h0000), 0);
    send_request(make_request(REQ_REGISTER, 32'h8000_0000, 16'h7FFE), 0);
    send_request(make_request(REQ_REGISTER, 32'h5555_5555, 16'hAAAA), 0);
    send_request(make_request(REQ_RESOLVE,  32'h8000_0000, 16'h0000), 0);
    send_request(make_request(REQ_FORGET,   32'hFFFF_FFFF, 16'h0000), 0);
    send_request(make_request(REQ_REGISTER, 32'h7FFF_FFFE, 16'h5555), 0);
    send_request(make_request(REQ_RESOLVE,  32'h5555_5555, 16'h0000), 0);

    // random: phases with and without sender idling, alternating fill and drain stretches
    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(random_request(((n / 120) % 2) == 0), idle_by_phase[phase]);
      end
    end
    start <= 1'b0;

    // drain
    while (outstanding != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
